@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files of the lexer project.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/srclx_pkg.sv @@
// Shared types, constants and keyword table of the source text lexer.
// Depends on nothing; every other file of the block but assert_macros.svh imports it.
package srclx_pkg;

    // Sizes of offsets, result fields, keyword buffer and run queue.
    localparam int OFFSET_BITS     = 24;
    localparam int KEYWORD_MAX_LEN = 6;
    localparam int IDX_BITS        = $clog2(KEYWORD_MAX_LEN);
    localparam int FIELD_BITS      = 24;
    localparam int RUN_MAX         = 3;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int KEYWORD_COUNT   = 16;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [FIELD_BITS-1:0]  field_t;
    typedef logic [5:0]             kind_t;
    typedef logic [KEYWORD_MAX_LEN-1:0][7:0] prefix_t;

    localparam offset_t OFFSET_MAX = '1;
    localparam field_t  FIELD_MAX  = '1;

    // Token kinds.
    localparam kind_t K_END     = 6'd0;
    localparam kind_t K_UNTERM  = 6'd1;
    localparam kind_t K_BAD     = 6'd2;
    localparam kind_t K_IDENT   = 6'd3;
    localparam kind_t K_NUMBER  = 6'd4;
    localparam kind_t K_STRING  = 6'd5;
    localparam kind_t K_LPAREN  = 6'd6;
    localparam kind_t K_RPAREN  = 6'd7;
    localparam kind_t K_LBRACE  = 6'd8;
    localparam kind_t K_RBRACE  = 6'd9;
    localparam kind_t K_COMMA   = 6'd10;
    localparam kind_t K_DOT     = 6'd11;
    localparam kind_t K_MINUS   = 6'd12;
    localparam kind_t K_PLUS    = 6'd13;
    localparam kind_t K_SEMI    = 6'd14;
    localparam kind_t K_SLASH   = 6'd15;
    localparam kind_t K_STAR    = 6'd16;
    localparam kind_t K_BANG    = 6'd17;
    localparam kind_t K_BANG_EQ = 6'd18;
    localparam kind_t K_EQ      = 6'd19;
    localparam kind_t K_EQ_EQ   = 6'd20;
    localparam kind_t K_GT      = 6'd21;
    localparam kind_t K_GT_EQ   = 6'd22;
    localparam kind_t K_LT      = 6'd23;
    localparam kind_t K_LT_EQ   = 6'd24;
    localparam kind_t K_AND     = 6'd25;
    localparam kind_t K_CLASS   = 6'd26;
    localparam kind_t K_ELSE    = 6'd27;
    localparam kind_t K_FALSE   = 6'd28;
    localparam kind_t K_FOR     = 6'd29;
    localparam kind_t K_IF      = 6'd30;
    localparam kind_t K_NIL     = 6'd31;
    localparam kind_t K_OR      = 6'd32;
    localparam kind_t K_PRINT   = 6'd33;
    localparam kind_t K_PROC    = 6'd34;
    localparam kind_t K_RETURN  = 6'd35;
    localparam kind_t K_SUPER   = 6'd36;
    localparam kind_t K_THIS    = 6'd37;
    localparam kind_t K_TRUE    = 6'd38;
    localparam kind_t K_VAR     = 6'd39;
    localparam kind_t K_WHILE   = 6'd40;

    // Character codes that the scanner tests for.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // One token and one run of tokens released by a single request.
    typedef struct packed {
        kind_t  kind;
        field_t start;
        field_t length;
    } token_t;

    typedef struct packed {
        token_t [RUN_MAX-1:0] tok;
        logic   [1:0]         count;
        field_t               line;
    } run_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Keyword table: text is right aligned, first character highest.
    typedef struct packed {
        logic [63:0] text;
        logic [3:0]  len;
        kind_t       kind;
    } kw_entry_t;

    function automatic kw_entry_t kw_entry(input logic [3:0] idx);
        kw_entry_t e;
        case (idx)
            4'd0:  e = '{text: 64'("and"),    len: 4'd3, kind: K_AND};
            4'd1:  e = '{text: 64'("class"),  len: 4'd5, kind: K_CLASS};
            4'd2:  e = '{text: 64'("else"),   len: 4'd4, kind: K_ELSE};
            4'd3:  e = '{text: 64'("false"),  len: 4'd5, kind: K_FALSE};
            4'd4:  e = '{text: 64'("for"),    len: 4'd3, kind: K_FOR};
            4'd5:  e = '{text: 64'("if"),     len: 4'd2, kind: K_IF};
            4'd6:  e = '{text: 64'("nil"),    len: 4'd3, kind: K_NIL};
            4'd7:  e = '{text: 64'("or"),     len: 4'd2, kind: K_OR};
            4'd8:  e = '{text: 64'("print"),  len: 4'd5, kind: K_PRINT};
            4'd9:  e = '{text: 64'("proc"),   len: 4'd4, kind: K_PROC};
            4'd10: e = '{text: 64'("return"), len: 4'd6, kind: K_RETURN};
            4'd11: e = '{text: 64'("super"),  len: 4'd5, kind: K_SUPER};
            4'd12: e = '{text: 64'("this"),   len: 4'd4, kind: K_THIS};
            4'd13: e = '{text: 64'("true"),   len: 4'd4, kind: K_TRUE};
            4'd14: e = '{text: 64'("var"),    len: 4'd3, kind: K_VAR};
            default: e = '{text: 64'("while"), len: 4'd5, kind: K_WHILE};
        endcase
        return e;
    endfunction

    // Kind of an identifier from its stored prefix and its length.
    function automatic kind_t word_kind(input prefix_t pre, input offset_t len);
        kind_t     k;
        kw_entry_t e;
        logic      hit;
        k = K_IDENT;
        if (len >= offset_t'(2) && len <= offset_t'(KEYWORD_MAX_LEN)) begin
            for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
                e   = kw_entry(4'(i));
                hit = (offset_t'(e.len) == len);
                for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                    if (j < int'(e.len)) begin
                        if (pre[j] != e.text[8*(int'(e.len)-1-j) +: 8]) begin
                            hit = 1'b0;
                        end
                    end
                end
                if (hit) begin
                    k = e.kind;
                end
            end
        end
        return k;
    endfunction

    // Length field from an end offset (one bit wider) and a start offset.
    function automatic field_t field_len(input logic [OFFSET_BITS:0] fin,
                                         input offset_t st);
        logic [OFFSET_BITS:0] d;
        d = '0;
        if (fin > {1'b0, st}) begin
            d = fin - {1'b0, st};
        end
        if (34'(d) > 34'(FIELD_MAX)) begin
            return FIELD_MAX;
        end
        return FIELD_BITS'(d);
    endfunction

    // Start field from an offset.
    function automatic field_t field_start(input offset_t st);
        return FIELD_BITS'(st);
    endfunction

endpackage

@@ src/srclx_front.sv @@
// Front of the lexer: accepts bytes, tracks the scan mode and builds token runs.
// Depends on srclx_pkg; feeds srclx_queue.
module srclx_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  logic [7:0]            char_code,
    input  logic                  end_of_source,
    input  srclx_pkg::q_status_t  q_status,
    output logic                  push,
    output srclx_pkg::run_t       run
);
    import srclx_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION,
        M_STRING, M_BANG, M_EQUAL, M_LESS, M_GREATER
    } mode_t;

    mode_t   mode_reg, mode_next;
    offset_t pos_reg, pos_next;
    offset_t tb_reg, tb_next;
    field_t  line_reg, line_next;
    prefix_t prefix_reg;

    logic                 accept;
    logic                 is_end;
    logic                 is_alpha;
    logic                 is_digit;
    logic [OFFSET_BITS:0] p_ext;
    logic [OFFSET_BITS:0] p_inc;
    offset_t              dot;
    offset_t              word_len;
    kind_t                cmp_kind;
    token_t               rel0, rel1, tail;
    logic [1:0]           rel_n, n_rel;
    logic                 use_rel, tail_v, do_idle, line_up, pre_we;
    logic [IDX_BITS-1:0]  pre_idx;

    // Handshake: a request is taken whenever the queue has room.
    assign accept    = src_valid && !q_status.full;
    assign src_stall = q_status.full;

    // Byte classes and offsets derived from the current position.
    assign is_end   = end_of_source || (char_code == CH_NUL);
    assign is_alpha = (char_code >= 8'h61 && char_code <= 8'h7A) ||
                      (char_code >= 8'h41 && char_code <= 8'h5A) || (char_code == 8'h5F);
    assign is_digit = (char_code >= 8'h30 && char_code <= 8'h39);
    assign p_ext    = {1'b0, pos_reg};
    assign p_inc    = p_ext + {{OFFSET_BITS{1'b0}}, 1'b1};
    assign dot      = (pos_reg != '0) ? pos_reg - offset_t'(1) : '0;
    assign word_len = (pos_reg > tb_reg) ? pos_reg - tb_reg : '0;

    // Single-character kind of a pending comparison operator.
    always_comb
    begin
        unique case (mode_reg)
            M_BANG:  cmp_kind = K_BANG;
            M_EQUAL: cmp_kind = K_EQ;
            M_LESS:  cmp_kind = K_LT;
            default: cmp_kind = K_GT;
        endcase
    end

    // Tokens that the pending mode releases when the next byte ends it.
    always_comb
    begin
        rel_n = 2'd0;
        rel0  = '0;
        rel1  = '0;
        unique case (mode_reg)
            M_IDENT:
            begin
                rel0  = '{kind: word_kind(prefix_reg, word_len),
                          start: field_start(tb_reg), length: field_len(p_ext, tb_reg)};
                rel_n = 2'd1;
            end
            M_NUMBER, M_FRACTION:
            begin
                rel0  = '{kind: K_NUMBER, start: field_start(tb_reg),
                          length: field_len(p_ext, tb_reg)};
                rel_n = 2'd1;
            end
            M_NUMDOT:
            begin
                rel0  = '{kind: K_NUMBER, start: field_start(tb_reg),
                          length: field_len({1'b0, dot}, tb_reg)};
                rel1  = '{kind: K_DOT, start: field_start(dot), length: field_t'(1)};
                rel_n = 2'd2;
            end
            M_SLASH:
            begin
                rel0  = '{kind: K_SLASH, start: field_start(tb_reg), length: field_t'(1)};
                rel_n = 2'd1;
            end
            M_BANG, M_EQUAL, M_LESS, M_GREATER:
            begin
                rel0  = '{kind: cmp_kind, start: field_start(tb_reg), length: field_t'(1)};
                rel_n = 2'd1;
            end
            M_STRING:
            begin
                // Only used at an end request: the string never closed.
                rel0  = '{kind: K_UNTERM, start: field_start(tb_reg),
                          length: field_len(p_ext, tb_reg)};
                rel_n = 2'd1;
            end
            default:
            begin
                rel_n = 2'd0;
            end
        endcase
    end

    // Next scan state and the token that the byte itself produces.
    always_comb
    begin
        mode_next = mode_reg;
        tb_next   = tb_reg;
        line_next = line_reg;
        pos_next  = pos_reg;
        use_rel   = 1'b0;
        tail_v    = 1'b0;
        tail      = '0;
        do_idle   = 1'b0;
        line_up   = 1'b0;
        pre_we    = 1'b0;
        pre_idx   = '0;
        if (is_end)
        begin
            use_rel   = 1'b1;
            tail_v    = 1'b1;
            tail      = '{kind: K_END, start: field_start(pos_reg), length: '0};
            mode_next = M_IDLE;
            pos_next  = '0;
            tb_next   = '0;
            line_next = field_t'(1);
        end
        else
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha || is_digit)
                    begin
                        if (pos_reg >= tb_reg && word_len < offset_t'(KEYWORD_MAX_LEN))
                        begin
                            pre_we  = 1'b1;
                            pre_idx = word_len[IDX_BITS-1:0];
                        end
                    end
                    else
                    begin
                        do_idle = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (char_code == CH_DOT)
                    begin
                        mode_next = M_NUMDOT;
                    end
                    else if (!is_digit)
                    begin
                        do_idle = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit)
                    begin
                        mode_next = M_FRACTION;
                    end
                    else
                    begin
                        do_idle = 1'b1;
                    end
                end
                M_FRACTION:
                begin
                    if (!is_digit)
                    begin
                        do_idle = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (char_code == CH_QUOTE)
                    begin
                        tail_v    = 1'b1;
                        tail      = '{kind: K_STRING, start: field_start(tb_reg),
                                      length: field_len(p_inc, tb_reg)};
                        mode_next = M_IDLE;
                    end
                    else if (char_code == CH_LF)
                    begin
                        line_up = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (char_code == CH_LF)
                    begin
                        line_up   = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
                M_SLASH:
                begin
                    if (char_code == CH_SLASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        do_idle = 1'b1;
                    end
                end
                M_BANG, M_EQUAL, M_LESS, M_GREATER:
                begin
                    if (char_code == CH_EQUAL)
                    begin
                        tail_v    = 1'b1;
                        tail      = '{kind: cmp_kind + kind_t'(1), start: field_start(tb_reg),
                                      length: field_len(p_inc, tb_reg)};
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // A byte that ends the pending token first releases it.
            if (do_idle && mode_reg != M_IDLE && mode_reg != M_COMMENT)
            begin
                use_rel = 1'b1;
            end

            // Scan the byte from the state between tokens.
            if (do_idle)
            begin
                tb_next   = pos_reg;
                mode_next = M_IDLE;
                tail      = '{kind: K_BAD, start: field_start(pos_reg), length: field_t'(1)};
                if (is_alpha)
                begin
                    mode_next = M_IDENT;
                    pre_we    = 1'b1;
                    pre_idx   = '0;
                end
                else if (is_digit)
                begin
                    mode_next = M_NUMBER;
                end
                else
                begin
                    case (char_code)
                        CH_SPACE, CH_CR, CH_TAB: ;
                        CH_LF:      line_up   = 1'b1;
                        CH_SLASH:   mode_next = M_SLASH;
                        CH_QUOTE:   mode_next = M_STRING;
                        CH_BANG:    mode_next = M_BANG;
                        CH_EQUAL:   mode_next = M_EQUAL;
                        CH_LESS:    mode_next = M_LESS;
                        CH_GREATER: mode_next = M_GREATER;
                        CH_LPAREN:  begin tail_v = 1'b1; tail.kind = K_LPAREN; end
                        CH_RPAREN:  begin tail_v = 1'b1; tail.kind = K_RPAREN; end
                        CH_LBRACE:  begin tail_v = 1'b1; tail.kind = K_LBRACE; end
                        CH_RBRACE:  begin tail_v = 1'b1; tail.kind = K_RBRACE; end
                        CH_COMMA:   begin tail_v = 1'b1; tail.kind = K_COMMA; end
                        CH_DOT:     begin tail_v = 1'b1; tail.kind = K_DOT; end
                        CH_MINUS:   begin tail_v = 1'b1; tail.kind = K_MINUS; end
                        CH_PLUS:    begin tail_v = 1'b1; tail.kind = K_PLUS; end
                        CH_SEMI:    begin tail_v = 1'b1; tail.kind = K_SEMI; end
                        CH_STAR:    begin tail_v = 1'b1; tail.kind = K_STAR; end
                        default:    tail_v = 1'b1;
                    endcase
                end
            end

            // Newlines count after any release, and counters saturate.
            if (line_up && line_reg != FIELD_MAX)
            begin
                line_next = line_reg + field_t'(1);
            end
            if (pos_reg != OFFSET_MAX)
            begin
                pos_next = pos_reg + offset_t'(1);
            end
        end
    end

    // Pack released tokens ahead of the byte's own token.
    always_comb
    begin
        n_rel   = use_rel ? rel_n : 2'd0;
        run.tok = '0;
        case (n_rel)
            2'd2:
            begin
                run.tok[0] = rel0;
                run.tok[1] = rel1;
                run.tok[2] = tail;
            end
            2'd1:
            begin
                run.tok[0] = rel0;
                run.tok[1] = tail;
            end
            default:
            begin
                run.tok[0] = tail;
            end
        endcase
        run.count = n_rel + {1'b0, tail_v};
        run.line  = line_reg;
        push      = accept && (run.count != 2'd0);
    end

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            tb_reg   <= '0;
            line_reg <= field_t'(1);
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tb_reg   <= tb_next;
            line_reg <= line_next;
        end
    end

    // Identifier prefix buffer; entries are read only after being written.
    always_ff @(posedge clk)
    begin
        if (accept && pre_we)
        begin
            prefix_reg[pre_idx] <= char_code;
        end
    end

endmodule

@@ src/srclx_queue.sv @@
// Short queue of token runs between the lexer front and the token back end.
// Depends on srclx_pkg.
module srclx_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  srclx_pkg::run_t       run_in,
    input  logic                  pop,
    output srclx_pkg::run_t       head,
    output srclx_pkg::q_status_t  status
);
    import srclx_pkg::*;

    run_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   cnt_reg, cnt_next;

    // Status and head of the queue.
    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));

    // Fill count follows pushes and pops.
    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + (QPTR_BITS+1)'(1);
            2'b01:   cnt_next = cnt_reg - (QPTR_BITS+1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Run storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= run_in;
        end
    end

endmodule

@@ src/srclx_emit.sv @@
// Back end of the lexer: hands out the tokens of the head run one per request.
// Depends on srclx_pkg; reads srclx_queue.
module srclx_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  srclx_pkg::run_t       head,
    input  srclx_pkg::q_status_t  q_status,
    output logic                  pop,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output logic [5:0]            token_kind,
    output logic [23:0]           token_start,
    output logic [23:0]           token_length,
    output logic [23:0]           token_line,
    output logic                  last_of_run
);
    import srclx_pkg::*;

    logic [1:0] sub_reg;
    token_t     cur;
    logic       taken;

    // Select the current token of the head run.
    assign cur          = head.tok[sub_reg];
    assign tok_valid    = !q_status.empty;
    assign token_kind   = cur.kind;
    assign token_start  = cur.start;
    assign token_length = cur.length;
    assign token_line   = head.line;
    assign last_of_run  = (sub_reg == head.count - 2'd1);
    assign taken        = tok_valid && !tok_stall;
    assign pop          = taken && last_of_run;

    // Token index within the head run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 2'd0;
        end
        else if (taken)
        begin
            sub_reg <= last_of_run ? 2'd0 : sub_reg + 2'd1;
        end
    end

endmodule

@@ src/source_text_lexer.sv @@
// Source text lexer: streams bytes in and tokens out.
// Uses srclx_pkg, srclx_front, srclx_queue and srclx_emit.
//
// Usage: source bytes arrive on char_code with src_valid; src_stall holds them.
// end_of_source (or a zero byte) ends a source: pending tokens are flushed, an
// end token follows, and position and line restart at 0 and 1.
// Tokens leave on token_kind, token_start, token_length, token_line with
// tok_valid; the receiver holds a token by raising tok_stall.
// last_of_run marks the last token caused by one input byte.
// A token released by a byte is registered in the run queue when that byte is
// accepted. The front takes one byte per cycle while src_stall is low; the back
// hands out one token per cycle while tok_stall is low. A byte may release up to
// three tokens, which the back hands out one by one while the front keeps taking bytes.
// A four-run queue sits between front and back: src_stall rises only when it
// is full, so a stalled receiver stops intake after four token runs.
// Reset clears the scan mode, offsets and the queue, and sets the line count to one.
module source_text_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_source,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [5:0]  token_kind,
    output logic [23:0] token_start,
    output logic [23:0] token_length,
    output logic [23:0] token_line,
    output logic        last_of_run
);
    import srclx_pkg::*;

    run_t      run_w, head_w;
    q_status_t q_status_w;
    logic      push_w, pop_w;

    // Byte intake and classification.
    srclx_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .char_code     (char_code),
        .end_of_source (end_of_source),
        .q_status      (q_status_w),
        .push          (push_w),
        .run           (run_w)
    );

    // Run queue.
    srclx_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push_w),
        .run_in (run_w),
        .pop    (pop_w),
        .head   (head_w),
        .status (q_status_w)
    );

    // Token output.
    srclx_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_w),
        .q_status     (q_status_w),
        .pop          (pop_w),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .last_of_run  (last_of_run)
    );

endmodule

@@ src/srclx_checker.sv @@
// Port-level checker for the source text lexer and its bind statement.
// Depends on srclx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srclx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        src_stall,
    input logic        tok_valid,
    input logic        tok_stall,
    input logic [5:0]  token_kind,
    input logic [23:0] token_start,
    input logic [23:0] token_length,
    input logic [23:0] token_line,
    input logic        last_of_run
);
    import srclx_pkg::*;

    // A stalled token stays offered unchanged.
    `CHK_NEXT(a_tok_hold, tok_valid && tok_stall, tok_valid && $stable(token_kind) && $stable(token_start) && $stable(token_length) && $stable(token_line) && $stable(last_of_run), "stalled token changed")

    // The end token is empty and closes its run.
    `CHK_IMPL(a_end_last, tok_valid && token_kind == K_END, token_length == '0 && last_of_run, "end token not empty or not last")

    // Lines start at one and kinds stay in the table.
    `CHK_IMPL(a_line_kind, tok_valid, token_line != '0 && token_kind <= K_WHILE, "bad line or kind")

    // Bad characters and one-byte operators are one byte long.
    `CHK_IMPL(a_one_byte, tok_valid && (token_kind == K_BAD || token_kind == K_LPAREN || token_kind == K_SEMI || token_kind == K_STAR), token_length == 24'd1, "one-byte token with wrong length")

    // An empty queue cannot be full in the next cycle, so intake is not stalled.
    `CHK_NEXT(a_no_early_stall, !tok_valid, !src_stall, "request stalled with queue nearly empty")

endmodule

bind source_text_lexer srclx_checker u_checker (.*);

@@ tb/sv/tb_srclx_pkg.sv @@
// Scoreboard of the source text lexer testbench: a token predictor and its checker.
// Depends on srclx_pkg for offset, field and token kind types.
package tb_srclx_pkg;
    import srclx_pkg::*;

    // Scan modes of the predictor; the lexer holds one pending token at most, or a number and its dot.
    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_SLASH, SCAN_COMMENT, SCAN_IDENT, SCAN_NUMBER, SCAN_NUMDOT,
        SCAN_FRACTION, SCAN_STRING, SCAN_BANG, SCAN_EQUAL, SCAN_LESS, SCAN_GREATER
    } scan_mode_e;

    // Letter and digit bounds that the scanner tests for.
    localparam logic [7:0] CH_LOW_A      = "a";
    localparam logic [7:0] CH_LOW_Z      = "z";
    localparam logic [7:0] CH_UP_A       = "A";
    localparam logic [7:0] CH_UP_Z       = "Z";
    localparam logic [7:0] CH_UNDERSCORE = "_";
    localparam logic [7:0] CH_ZERO       = "0";
    localparam logic [7:0] CH_NINE       = "9";

    // Keywords and the kinds they map to.
    string KEYWORDS[16] = '{"and", "class", "else", "false", "for", "if", "nil", "or",
                            "print", "proc", "return", "super", "this", "true", "var",
                            "while"};
    kind_t KEYWORD_KINDS[16] = '{K_AND, K_CLASS, K_ELSE, K_FALSE, K_FOR, K_IF, K_NIL,
                                 K_OR, K_PRINT, K_PROC, K_RETURN, K_SUPER, K_THIS,
                                 K_TRUE, K_VAR, K_WHILE};

    typedef struct {
        kind_t  kind;
        field_t start;
        field_t length;
        field_t line;
        logic   last;
    } token_rec_t;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               c == CH_UNDERSCORE;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    class lexer_scoreboard;
        token_rec_t expected_tokens[$];
        scan_mode_e mode;
        offset_t    pos;
        offset_t    tok_begin;
        field_t     line;
        logic [7:0] prefix[KEYWORD_MAX_LEN];
        int         errors;
        int         tokens_expected;
        int         tokens_checked;

        function new();
            restart();
            errors          = 0;
            tokens_expected = 0;
            tokens_checked  = 0;
        endfunction

        // Scan state at reset and after every end of source.
        function void restart();
            mode      = SCAN_IDLE;
            pos       = '0;
            tok_begin = '0;
            line      = field_t'(1);
        endfunction

        function void bump_line();
            if (line != FIELD_MAX)
                line++;
        endfunction

        // Queues one token running from offset st up to (not including) fin.
        function void push_token(kind_t k, longint unsigned st, longint unsigned fin);
            longint unsigned len;
            token_rec_t      t;
            len = (fin > st) ? fin - st : 0;
            if (len > FIELD_MAX)
                len = FIELD_MAX;
            t.kind   = k;
            t.start  = field_t'(st);
            t.length = field_t'(len);
            t.line   = line;
            t.last   = 1'b0;
            expected_tokens.push_back(t);
            tokens_expected++;
        endfunction

        // An identifier is a keyword only when its whole text fits the prefix.
        function kind_t keyword_of(longint unsigned len);
            kind_t k;
            bit    hit;
            k = K_IDENT;
            if (len >= 2 && len <= KEYWORD_MAX_LEN) begin
                for (int i = 0; i < 16; i++) begin
                    if (KEYWORDS[i].len() == len) begin
                        hit = 1'b1;
                        for (int j = 0; j < len; j++) begin
                            if (prefix[j] != KEYWORDS[i][j])
                                hit = 1'b0;
                        end
                        if (hit)
                            k = KEYWORD_KINDS[i];
                    end
                end
            end
            return k;
        endfunction

        // Kind of a comparison operator standing alone; with '=' it is one higher.
        function kind_t lone_kind(scan_mode_e m);
            case (m)
                SCAN_BANG:  return K_BANG;
                SCAN_EQUAL: return K_EQ;
                SCAN_LESS:  return K_LT;
                default:    return K_GT;
            endcase
        endfunction

        // Releases the pending token as if it ended at offset p.
        function void release_pending(offset_t p);
            offset_t dot;
            dot = (p != '0) ? p - offset_t'(1) : '0;
            case (mode)
                SCAN_IDENT:
                    push_token(keyword_of((p > tok_begin) ? p - tok_begin : 0), tok_begin, p);
                SCAN_NUMBER, SCAN_FRACTION:
                    push_token(K_NUMBER, tok_begin, p);
                SCAN_NUMDOT:
                begin
                    push_token(K_NUMBER, tok_begin, dot);
                    push_token(K_DOT, dot, longint'(dot) + 1);
                end
                SCAN_SLASH:
                    push_token(K_SLASH, tok_begin, longint'(tok_begin) + 1);
                SCAN_BANG, SCAN_EQUAL, SCAN_LESS, SCAN_GREATER:
                    push_token(lone_kind(mode), tok_begin, longint'(tok_begin) + 1);
                default:
                    ;
            endcase
            mode = SCAN_IDLE;
        endfunction

        // Starts a new token, or emits a single-character one, at offset p.
        function void scan_idle(logic [7:0] c, offset_t p);
            kind_t k;
            tok_begin = p;
            if (is_letter(c)) begin
                mode      = SCAN_IDENT;
                prefix[0] = c;
                return;
            end
            if (is_digit(c)) begin
                mode = SCAN_NUMBER;
                return;
            end
            case (c)
                CH_SPACE, CH_CR, CH_TAB: return;
                CH_LF:
                begin
                    bump_line();
                    return;
                end
                CH_SLASH:   begin mode = SCAN_SLASH;   return; end
                CH_QUOTE:   begin mode = SCAN_STRING;  return; end
                CH_BANG:    begin mode = SCAN_BANG;    return; end
                CH_EQUAL:   begin mode = SCAN_EQUAL;   return; end
                CH_LESS:    begin mode = SCAN_LESS;    return; end
                CH_GREATER: begin mode = SCAN_GREATER; return; end
                CH_LPAREN:  k = K_LPAREN;
                CH_RPAREN:  k = K_RPAREN;
                CH_LBRACE:  k = K_LBRACE;
                CH_RBRACE:  k = K_RBRACE;
                CH_COMMA:   k = K_COMMA;
                CH_DOT:     k = K_DOT;
                CH_MINUS:   k = K_MINUS;
                CH_PLUS:    k = K_PLUS;
                CH_SEMI:    k = K_SEMI;
                CH_STAR:    k = K_STAR;
                default:    k = K_BAD;
            endcase
            push_token(k, p, longint'(p) + 1);
        endfunction

        // One ordinary source byte: continue the pending token or rescan.
        function void scan_byte(logic [7:0] c);
            offset_t         p;
            bit              rescan;
            longint unsigned idx;
            p      = pos;
            rescan = 1'b0;
            case (mode)
                SCAN_IDENT:
                    if (is_letter(c) || is_digit(c)) begin
                        idx = p - tok_begin;
                        if (p >= tok_begin && idx < KEYWORD_MAX_LEN)
                            prefix[idx] = c;
                    end else begin
                        rescan = 1'b1;
                    end
                SCAN_NUMBER:
                    if (c == CH_DOT)
                        mode = SCAN_NUMDOT;
                    else if (!is_digit(c))
                        rescan = 1'b1;
                SCAN_NUMDOT:
                    if (is_digit(c))
                        mode = SCAN_FRACTION;
                    else
                        rescan = 1'b1;
                SCAN_FRACTION:
                    if (!is_digit(c))
                        rescan = 1'b1;
                SCAN_STRING:
                    if (c == CH_QUOTE) begin
                        push_token(K_STRING, tok_begin, longint'(p) + 1);
                        mode = SCAN_IDLE;
                    end else if (c == CH_LF) begin
                        bump_line();
                    end
                SCAN_COMMENT:
                    if (c == CH_LF) begin
                        bump_line();
                        mode = SCAN_IDLE;
                    end
                SCAN_SLASH:
                    if (c == CH_SLASH)
                        mode = SCAN_COMMENT;
                    else
                        rescan = 1'b1;
                SCAN_BANG, SCAN_EQUAL, SCAN_LESS, SCAN_GREATER:
                    if (c == CH_EQUAL) begin
                        push_token(kind_t'(lone_kind(mode) + 1), tok_begin, longint'(p) + 1);
                        mode = SCAN_IDLE;
                    end else begin
                        rescan = 1'b1;
                    end
                default:
                begin
                    mode = SCAN_IDLE;
                    scan_idle(c, p);
                end
            endcase
            if (rescan) begin
                release_pending(p);
                scan_idle(c, p);
            end
            if (pos != OFFSET_MAX)
                pos++;
        endfunction

        // Works out the tokens that one accepted request releases.
        function void note_request(logic [7:0] c, logic eos);
            int      first;
            offset_t p;
            first = expected_tokens.size();
            if (eos || c == CH_NUL) begin
                p = pos;
                if (mode == SCAN_STRING)
                    push_token(K_UNTERM, tok_begin, p);
                else
                    release_pending(p);
                push_token(K_END, p, p);
                restart();
            end else begin
                scan_byte(c);
            end
            if (expected_tokens.size() > first)
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: token %0d %s mismatch, expected %0d, got %0d",
                             $time, tokens_checked, name, want, got);
            end
        endfunction

        // Compares one accepted token with the oldest expectation.
        function void check_token(kind_t k, field_t st, field_t len, field_t ln, logic last);
            token_rec_t e;
            tokens_checked++;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected token, expected none, got kind %0d start %0d",
                             $time, k, st);
                return;
            end
            e = expected_tokens.pop_front();
            compare_field("kind", 24'(e.kind), 24'(k));
            compare_field("start", e.start, st);
            compare_field("length", e.length, len);
            compare_field("line", e.line, ln);
            compare_field("last_of_run", 24'(e.last), 24'(last));
        endfunction

        function void report_leftover();
            if (expected_tokens.size() != 0) begin
                errors += expected_tokens.size();
                $display("%0t: %0d expected tokens never arrived, first kind %0d start %0d",
                         $time, expected_tokens.size(), expected_tokens[0].kind,
                         expected_tokens[0].start);
            end
        endfunction
    endclass

endpackage

@@ tb/sv/tb_source_text_lexer.sv @@
// Top of the source text lexer testbench: clock, reset, byte driver and token monitor.
// Depends on srclx_pkg, tb_srclx_pkg and the source_text_lexer RTL.
module tb_source_text_lexer;
    import srclx_pkg::*;
    import tb_srclx_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic [7:0]  char_code;
    logic        end_of_source;
    logic        tok_valid;
    logic        tok_stall;
    logic [5:0]  token_kind;
    logic [23:0] token_start;
    logic [23:0] token_length;
    logic [23:0] token_line;
    logic        last_of_run;

    lexer_scoreboard sb = new();
    logic [7:0]      source_bytes[$];
    bit              calm;
    int              requests_sent;
    int              sources_ended;

    source_text_lexer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .char_code    (char_code),
        .end_of_source(end_of_source),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .last_of_run  (last_of_run)
    );

    // Free-running clock, period 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Gap length: mostly none or short, now and then long; none in calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one request after a random gap and waits until it is accepted.
    task automatic send_request(input logic [7:0] c, input logic eos);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            src_valid <= 1'b0;
        end
        @(negedge clk);
        src_valid     <= 1'b1;
        char_code     <= c;
        end_of_source <= eos;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        sb.note_request(c, eos);
        requests_sent++;
        if (eos || c == CH_NUL)
            sources_ended++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], 1'b0);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            source_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CH_LOW_A + 8'(r);
        if (r < 52)
            return CH_UP_A + 8'(r - 26);
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Appends one random token's text, well formed most of the time.
    task automatic add_lexeme();
        string ops[19] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "/", "*",
                           "!", "!=", "=", "==", "<", "<=", ">", ">="};
        string blanks[4] = '{" ", "\t", "\r", "\n"};
        int    r;
        int    n;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            push_text(KEYWORDS[$urandom_range(0, 15)]);
        end else if (r < 35) begin
            n = $urandom_range(1, 9);
            source_bytes.push_back(rand_letter());
            for (int i = 1; i < n; i++)
                source_bytes.push_back(($urandom_range(0, 3) == 0) ? rand_digit()
                                                                    : rand_letter());
        end else if (r < 50) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                source_bytes.push_back(rand_digit());
            n = $urandom_range(0, 3);
            if (n > 0)
                source_bytes.push_back(CH_DOT);
            for (int i = 1; i < n; i++)
                source_bytes.push_back(rand_digit());
        end else if (r < 60) begin
            source_bytes.push_back(CH_QUOTE);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                c = ($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom_range(32, 126));
                source_bytes.push_back((c == CH_QUOTE) ? CH_SPACE : c);
            end
            if ($urandom_range(0, 9) != 0)
                source_bytes.push_back(CH_QUOTE);
        end else if (r < 82) begin
            push_text(ops[$urandom_range(0, 18)]);
        end else if (r < 88) begin
            push_text("//");
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                source_bytes.push_back(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 4) != 0)
                source_bytes.push_back(CH_LF);
        end else if (r < 94) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_text(blanks[$urandom_range(0, 3)]);
        end else begin
            source_bytes.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 8))
                                                               : 8'($urandom_range(128, 255)));
        end
    endtask

    // Receiver stalls: free stretches alternate with random stalls.
    initial
    begin
        int run;
        int hold;
        tok_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (run)
            begin
                @(negedge clk);
                tok_stall <= 1'b0;
            end
            hold = pick_gap();
            repeat (hold)
            begin
                @(negedge clk);
                tok_stall <= 1'b1;
            end
        end
    end

    // Every accepted token goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && tok_valid && !tok_stall)
            sb.check_token(token_kind, token_start, token_length, token_line, last_of_run);
    end

    // Stimulus: directed sources, then random token streams, then drain.
    initial
    begin
        int r;
        int n;
        int waited;
        rst_n         = 1'b0;
        src_valid     = 1'b0;
        char_code     = 8'h00;
        end_of_source = 1'b0;
        calm          = 1'b0;
        requests_sent = 0;
        sources_ended = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Number then dot, a top-bit bad byte after an identifier.
        send_text("1.x");
        send_request(8'hFF, 1'b0);
        // String over two lines.
        send_text("\"a\nb\"");
        // Comparisons, a lone bang released by a slash, comment open at end.
        send_text("a<=!");
        send_text("// c");
        send_request(8'h5A, 1'b1);
        // Unterminated string closed by a zero byte, then an empty source.
        send_text("\"ab");
        send_request(CH_NUL, 1'b0);
        send_request(8'hFF, 1'b1);

        // Random sources of mostly well-formed tokens with some noise.
        while (requests_sent < 390)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                add_lexeme();
                if ($urandom_range(0, 4) < 3)
                    source_bytes.push_back(($urandom_range(0, 5) == 0) ? CH_LF : CH_SPACE);
                if ($urandom_range(0, 19) == 0)
                    source_bytes.push_back(8'($urandom_range(0, 255)));
            end
            while (source_bytes.size() != 0)
                send_request(source_bytes.pop_front(), 1'b0);
            r = $urandom_range(0, 9);
            if (r < 7)
                send_request(8'($urandom_range(0, 255)), 1'b1);
            else if (r < 9)
                send_request(CH_NUL, 1'b0);
        end
        send_request(8'($urandom_range(0, 255)), 1'b1);
        @(negedge clk);
        src_valid <= 1'b0;

        // Drain the remaining tokens, then wait quietly before the report.
        calm   = 1'b1;
        waited = 0;
        while (sb.expected_tokens.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        sb.report_leftover();

        $display("Run covered %0d requests over %0d sources; %0d tokens predicted, %0d checked.",
                 requests_sent, sources_ended, sb.tokens_expected, sb.tokens_checked);
        if (sb.errors == 0)
            $display("[source_text_lexer] OK");
        else
            $display("[source_text_lexer] ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5000000;
        $display("[source_text_lexer] ERROR");
        $finish;
    end

endmodule
